### hdl/h2t_pkg.sv
// Shared types, character codes and helper functions for the HTML to plain text stream.
// Used by the top level, front end, queue and output sequencer; depends on nothing else.
package h2t_pkg;

	localparam int unsigned UNIT_W      = 16;
	localparam int unsigned NAME_DEPTH  = 4;
	localparam int unsigned NAME_LEN_W  = 3;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	localparam logic [NAME_LEN_W-1:0] NAME_TOO_LONG = 3'd5;
	localparam logic [NAME_LEN_W-1:0] NAME_FULL     = 3'd4;

	localparam logic [UNIT_W-1:0] CH_NEWLINE = 16'h000A;
	localparam logic [UNIT_W-1:0] CH_SPACE   = 16'h0020;
	localparam logic [UNIT_W-1:0] CH_NBSP    = 16'h00A0;
	localparam logic [UNIT_W-1:0] CH_LT      = 16'h003C;
	localparam logic [UNIT_W-1:0] CH_GT      = 16'h003E;
	localparam logic [UNIT_W-1:0] CH_AMP     = 16'h0026;
	localparam logic [UNIT_W-1:0] CH_SEMI    = 16'h003B;
	localparam logic [UNIT_W-1:0] CH_QUOTE   = 16'h0022;
	localparam logic [UNIT_W-1:0] CH_APOS    = 16'h0027;
	localparam logic [UNIT_W-1:0] CH_SLASH   = 16'h002F;
	localparam logic [UNIT_W-1:0] CH_A       = 16'h0061;
	localparam logic [UNIT_W-1:0] CH_B       = 16'h0062;
	localparam logic [UNIT_W-1:0] CH_G       = 16'h0067;
	localparam logic [UNIT_W-1:0] CH_L       = 16'h006C;
	localparam logic [UNIT_W-1:0] CH_M       = 16'h006D;
	localparam logic [UNIT_W-1:0] CH_O       = 16'h006F;
	localparam logic [UNIT_W-1:0] CH_P       = 16'h0070;
	localparam logic [UNIT_W-1:0] CH_Q       = 16'h0071;
	localparam logic [UNIT_W-1:0] CH_R       = 16'h0072;
	localparam logic [UNIT_W-1:0] CH_S       = 16'h0073;
	localparam logic [UNIT_W-1:0] CH_T       = 16'h0074;
	localparam logic [UNIT_W-1:0] CH_U       = 16'h0075;

	typedef enum logic [2:0] {
		MODE_TEXT   = 3'b001,
		MODE_TAG    = 3'b010,
		MODE_ENTITY = 3'b100
	} parse_mode_t;

	// One queue entry holds every result that one input item causes.
	typedef struct packed {
		logic              nl_release;
		logic              char_valid;
		logic [UNIT_W-1:0] char_unit;
		logic              text_end;
	} result_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic is_blank(input logic [UNIT_W-1:0] c);
		logic r;
		r = 1'b0;
		if (c >= 16'h0009 && c <= 16'h000D) r = 1'b1;
		if (c == 16'h0020 || c == 16'h0085 || c == 16'h00A0 || c == 16'h1680) r = 1'b1;
		if (c >= 16'h2000 && c <= 16'h200A) r = 1'b1;
		if (c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
		    c == 16'h3000) r = 1'b1;
		return r;
	endfunction

endpackage

### hdl/html_to_plain_text_stream_top.sv
// HTML to plain text stream converter: top level.
// Instantiates h2t_front, h2t_queue and h2t_back; depends on h2t_pkg.
//
// Input channel s_*: one UTF-16 code unit of HTML text per transfer in s_tdata,
// with s_tlast marking the last code unit of a text. Output channel m_*: one
// plain text result per transfer; m_tdata is the character, m_tuser[0] says a
// character is present and m_tuser[1] marks the end-of-text result, which
// carries zero data. m_tlast marks the last result caused by one input unit.
// Input units that cause no result (markup, dropped white space) produce nothing.
// The results of a unit are registered in the result queue and offered from its head.
// Throughput: one input unit per cycle; the output sends one result per cycle,
// so units that cause two or three results fill the four-entry result queue,
// and s_tready falls while the queue is full.
// When the receiver stalls, results wait in the queue and the input keeps
// flowing until the queue fills. Reset empties the queue and returns the
// parser to text mode with no held newline; the end-of-text result also
// returns all parse state to that condition.
module html_to_plain_text_stream_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] code_unit
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [15:0] out_unit
	output logic [1:0]  m_tuser,  // [0] unit_valid, [1] text_end
	output logic        m_tlast
);

	h2t_pkg::result_entry_t push_entry, head;
	h2t_pkg::queue_status_t status;
	logic                   accept, push, pop;

	assign s_tready = !status.full;
	assign accept   = s_tvalid && s_tready;

	h2t_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.code_unit  (s_tdata),
		.final_unit (s_tlast),
		.push       (push),
		.push_entry (push_entry)
	);

	h2t_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (status)
	);

	h2t_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.status   (status),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### hdl/h2t_front.sv
// Front end: accepts code units, tracks tag and entity parsing and the output
// spacing state, and forms one queue entry per item. Depends on h2t_pkg.
module h2t_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [h2t_pkg::UNIT_W-1:0]        code_unit,
	input  logic                              final_unit,
	output logic                              push,
	output h2t_pkg::result_entry_t            push_entry
);

	h2t_pkg::parse_mode_t                  mode_q, mode_n;
	logic [h2t_pkg::UNIT_W-1:0]            units_q [h2t_pkg::NAME_DEPTH];
	logic [h2t_pkg::NAME_LEN_W-1:0]        len_q, len_n;
	logic                                  closed_q, closed_n;
	logic                                  nonempty_q, nonempty_n;
	logic                                  blank_q, blank_n;
	logic                                  held_q, held_n;
	logic                                  name_add;
	logic                                  do_char, do_nl;
	logic [h2t_pkg::UNIT_W-1:0]            char_unit;
	logic                                  is_br, is_p, is_endp;
	logic                                  is_amp, is_lt, is_gt, is_quot, is_apos;
	h2t_pkg::result_entry_t                entry;

	assign is_br   = len_q == 3'd2 && units_q[0] == h2t_pkg::CH_B && units_q[1] == h2t_pkg::CH_R;
	assign is_p    = len_q == 3'd1 && units_q[0] == h2t_pkg::CH_P;
	assign is_endp = len_q == 3'd2 && units_q[0] == h2t_pkg::CH_SLASH &&
	                 units_q[1] == h2t_pkg::CH_P;
	assign is_amp  = len_q == 3'd3 && units_q[0] == h2t_pkg::CH_A &&
	                 units_q[1] == h2t_pkg::CH_M && units_q[2] == h2t_pkg::CH_P;
	assign is_lt   = len_q == 3'd2 && units_q[0] == h2t_pkg::CH_L && units_q[1] == h2t_pkg::CH_T;
	assign is_gt   = len_q == 3'd2 && units_q[0] == h2t_pkg::CH_G && units_q[1] == h2t_pkg::CH_T;
	assign is_quot = len_q == 3'd4 && units_q[0] == h2t_pkg::CH_Q &&
	                 units_q[1] == h2t_pkg::CH_U && units_q[2] == h2t_pkg::CH_O &&
	                 units_q[3] == h2t_pkg::CH_T;
	assign is_apos = len_q == 3'd4 && units_q[0] == h2t_pkg::CH_A &&
	                 units_q[1] == h2t_pkg::CH_P && units_q[2] == h2t_pkg::CH_O &&
	                 units_q[3] == h2t_pkg::CH_S;

	always_comb begin
		mode_n    = mode_q;
		len_n     = len_q;
		closed_n  = closed_q;
		name_add  = 1'b0;
		do_char   = 1'b0;
		do_nl     = 1'b0;
		char_unit = code_unit;
		unique case (mode_q)
			h2t_pkg::MODE_TAG: begin
				if (code_unit == h2t_pkg::CH_GT) begin
					if (is_br) begin
						do_nl = 1'b1;
					end else if ((is_p || is_endp) && nonempty_q && !held_q) begin
						do_nl = 1'b1;
					end
					mode_n = h2t_pkg::MODE_TEXT;
				end else if (!closed_q) begin
					if (code_unit == h2t_pkg::CH_SPACE) begin
						closed_n = 1'b1;
					end else begin
						name_add = 1'b1;
					end
				end
			end
			h2t_pkg::MODE_ENTITY: begin
				if (code_unit == h2t_pkg::CH_SEMI) begin
					do_char = is_amp || is_lt || is_gt || is_quot || is_apos;
					if (is_amp) begin
						char_unit = h2t_pkg::CH_AMP;
					end else if (is_lt) begin
						char_unit = h2t_pkg::CH_LT;
					end else if (is_gt) begin
						char_unit = h2t_pkg::CH_GT;
					end else if (is_quot) begin
						char_unit = h2t_pkg::CH_QUOTE;
					end else begin
						char_unit = h2t_pkg::CH_APOS;
					end
					mode_n = h2t_pkg::MODE_TEXT;
				end else begin
					name_add = 1'b1;
				end
			end
			default: begin
				if (code_unit == h2t_pkg::CH_LT || code_unit == h2t_pkg::CH_AMP) begin
					mode_n   = (code_unit == h2t_pkg::CH_LT) ? h2t_pkg::MODE_TAG
					                                         : h2t_pkg::MODE_ENTITY;
					len_n    = '0;
					closed_n = 1'b0;
				end else if (code_unit == h2t_pkg::CH_NBSP) begin
					do_char   = 1'b1;
					char_unit = h2t_pkg::CH_SPACE;
				end else if (code_unit == h2t_pkg::CH_NEWLINE) begin
					do_char = 1'b0;
				end else if (h2t_pkg::is_blank(code_unit)) begin
					do_char   = !nonempty_q || !blank_q;
					char_unit = h2t_pkg::CH_SPACE;
				end else begin
					do_char = 1'b1;
				end
			end
		endcase

		if (name_add && len_q < h2t_pkg::NAME_TOO_LONG) begin
			len_n = len_q + 3'd1;
		end

		held_n     = held_q;
		nonempty_n = nonempty_q;
		blank_n    = blank_q;
		if (do_char) begin
			held_n     = 1'b0;
			nonempty_n = 1'b1;
			blank_n    = char_unit == h2t_pkg::CH_SPACE;
		end else if (do_nl) begin
			held_n     = 1'b1;
			nonempty_n = 1'b1;
			blank_n    = 1'b0;
		end

		entry.nl_release = (do_char || do_nl) && held_q;
		entry.char_valid = do_char;
		entry.char_unit  = char_unit;
		entry.text_end   = final_unit;
	end

	assign push       = accept && (entry.nl_release || entry.char_valid || entry.text_end);
	assign push_entry = entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= h2t_pkg::MODE_TEXT;
			len_q      <= '0;
			closed_q   <= 1'b0;
			nonempty_q <= 1'b0;
			blank_q    <= 1'b0;
			held_q     <= 1'b0;
		end else if (accept) begin
			if (final_unit) begin
				mode_q     <= h2t_pkg::MODE_TEXT;
				len_q      <= '0;
				closed_q   <= 1'b0;
				nonempty_q <= 1'b0;
				blank_q    <= 1'b0;
				held_q     <= 1'b0;
			end else begin
				mode_q     <= mode_n;
				len_q      <= len_n;
				closed_q   <= closed_n;
				nonempty_q <= nonempty_n;
				blank_q    <= blank_n;
				held_q     <= held_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && name_add && len_q < h2t_pkg::NAME_FULL) begin
			units_q[len_q[1:0]] <= code_unit;
		end
	end

endmodule

### hdl/h2t_queue.sv
// Short queue of result entries between the front end and the output sequencer.
// Depends on h2t_pkg.
module h2t_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  h2t_pkg::result_entry_t push_entry,
	input  logic                   pop,
	output h2t_pkg::result_entry_t head,
	output h2t_pkg::queue_status_t status
);

	h2t_pkg::result_entry_t        mem_q [h2t_pkg::QUEUE_DEPTH];
	logic [h2t_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [h2t_pkg::QCNT_W-1:0]    count_q;
	logic                          do_push, do_pop;

	assign status.full  = count_q == h2t_pkg::QCNT_W'(h2t_pkg::QUEUE_DEPTH);
	assign status.empty = count_q == '0;
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + h2t_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + h2t_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + h2t_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - h2t_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

### hdl/h2t_back.sv
// Output sequencer: sends the one to three results held in the queue head as
// separate transfers and pops the entry after the last one. Depends on h2t_pkg.
module h2t_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  h2t_pkg::result_entry_t     head,
	input  h2t_pkg::queue_status_t     status,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [h2t_pkg::UNIT_W-1:0] m_tdata,
	output logic [1:0]                 m_tuser,
	output logic                       m_tlast
);

	logic nl_done_q, ch_done_q;
	logic nl_pend, ch_pend;
	logic xfer;

	assign nl_pend  = head.nl_release && !nl_done_q;
	assign ch_pend  = head.char_valid && !ch_done_q;
	assign m_tvalid = !status.empty;
	assign xfer     = m_tvalid && m_tready;
	assign pop      = xfer && m_tlast;

	always_comb begin
		if (nl_pend) begin
			m_tdata = h2t_pkg::CH_NEWLINE;
			m_tuser = 2'b01;
			m_tlast = !head.char_valid && !head.text_end;
		end else if (ch_pend) begin
			m_tdata = head.char_unit;
			m_tuser = 2'b01;
			m_tlast = !head.text_end;
		end else begin
			m_tdata = '0;
			m_tuser = 2'b10;
			m_tlast = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nl_done_q <= 1'b0;
			ch_done_q <= 1'b0;
		end else if (xfer) begin
			if (m_tlast) begin
				nl_done_q <= 1'b0;
				ch_done_q <= 1'b0;
			end else if (nl_pend) begin
				nl_done_q <= 1'b1;
			end else begin
				ch_done_q <= 1'b1;
			end
		end
	end

endmodule

### hdl/h2t_checker.sv
// Port-level checks for the HTML to plain text stream converter, bound to the
// top level. Sees only the top-level ports.
module h2t_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Output transfer withdrawn while stalled.");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("End-of-text result is not the last result of its unit.");

	a_end_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata == 16'h0000)
		else $error("End-of-text result carries a character.");

	a_kind_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tuser[1])
		else $error("Result is neither a character nor an end marker.");

endmodule

bind html_to_plain_text_stream_top h2t_checker u_h2t_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

### bench/tb.sv
// Self-checking testbench for html_to_plain_text_stream_top.
// A scoreboard class predicts the plain text results of every accepted code unit and
// checks the output stream against them; depends on h2t_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_CYCLES    = 80;
	localparam int RANDOM_UNITS   = 220;
	localparam int DRAIN_CYCLES   = 20;

	typedef struct {
		logic [15:0] unit;
		logic        valid;
		logic        text_end;
		logic        last;
	} plain_result_t;

	typedef struct {
		logic [15:0] code;
		logic        fin;
	} html_unit_t;

	class plain_text_scoreboard;
		plain_result_t        plain_q[$];
		plain_result_t        step_q[$];
		int                   mismatches;
		h2t_pkg::parse_mode_t mode;
		logic [15:0]          name_buf[4];
		logic [2:0]           name_len;
		bit                   name_done;
		bit                   any_output;
		bit                   trailing_space;
		bit                   nl_pending;

		function new();
			mismatches = 0;
			clear_state();
		endfunction

		function void clear_state();
			mode = h2t_pkg::MODE_TEXT;
			name_len = 3'd0;
			name_done = 1'b0;
			any_output = 1'b0;
			trailing_space = 1'b0;
			nl_pending = 1'b0;
		endfunction

		function bit white_space(logic [15:0] c);
			if (c >= 16'h0009 && c <= 16'h000D) return 1'b1;
			if (c == 16'h0020 || c == 16'h0085 || c == 16'h00A0 || c == 16'h1680) return 1'b1;
			if (c >= 16'h2000 && c <= 16'h200A) return 1'b1;
			if (c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F) return 1'b1;
			return c == 16'h3000;
		endfunction

		function void add_result(logic [15:0] unit, logic valid, logic text_end);
			plain_result_t r;
			r.unit = unit;
			r.valid = valid;
			r.text_end = text_end;
			r.last = 1'b0;
			step_q.push_back(r);
		endfunction

		function void put_char(logic [15:0] c);
			if (nl_pending) begin
				add_result(h2t_pkg::CH_NEWLINE, 1'b1, 1'b0);
				nl_pending = 1'b0;
			end
			add_result(c, 1'b1, 1'b0);
			any_output = 1'b1;
			trailing_space = (c == h2t_pkg::CH_SPACE);
		endfunction

		function void put_newline();
			if (nl_pending)
				add_result(h2t_pkg::CH_NEWLINE, 1'b1, 1'b0);
			nl_pending = 1'b1;
			any_output = 1'b1;
			trailing_space = 1'b0;
		endfunction

		function void add_name_unit(logic [15:0] c);
			if (name_len < 3'd4)
				name_buf[name_len[1:0]] = c;
			if (name_len < 3'd5)
				name_len++;
		endfunction

		function bit name_equals(string w);
			if (name_len != w.len()) return 1'b0;
			for (int k = 0; k < w.len(); k++)
				if (name_buf[k] != {8'h00, w[k]}) return 1'b0;
			return 1'b1;
		endfunction

		function void close_tag();
			if (name_equals("br"))
				put_newline();
			if ((name_equals("p") || name_equals("/p")) && any_output && !nl_pending)
				put_newline();
		endfunction

		function void close_entity();
			if (name_equals("amp")) put_char(h2t_pkg::CH_AMP);
			else if (name_equals("lt")) put_char(h2t_pkg::CH_LT);
			else if (name_equals("gt")) put_char(h2t_pkg::CH_GT);
			else if (name_equals("quot")) put_char(h2t_pkg::CH_QUOTE);
			else if (name_equals("apos")) put_char(h2t_pkg::CH_APOS);
		endfunction

		function void predict_unit(logic [15:0] c, logic fin);
			step_q.delete();
			case (mode)
				h2t_pkg::MODE_TAG: begin
					if (c == h2t_pkg::CH_GT) begin
						close_tag();
						mode = h2t_pkg::MODE_TEXT;
					end else if (!name_done) begin
						if (c == h2t_pkg::CH_SPACE) name_done = 1'b1;
						else add_name_unit(c);
					end
				end
				h2t_pkg::MODE_ENTITY: begin
					if (c == h2t_pkg::CH_SEMI) begin
						close_entity();
						mode = h2t_pkg::MODE_TEXT;
					end else begin
						add_name_unit(c);
					end
				end
				default: begin
					if (c == h2t_pkg::CH_LT || c == h2t_pkg::CH_AMP) begin
						mode = (c == h2t_pkg::CH_LT) ? h2t_pkg::MODE_TAG : h2t_pkg::MODE_ENTITY;
						name_len = 3'd0;
						name_done = 1'b0;
					end else if (c == h2t_pkg::CH_NBSP) begin
						put_char(h2t_pkg::CH_SPACE);
					end else if (c == h2t_pkg::CH_NEWLINE) begin
					end else if (white_space(c)) begin
						if (!any_output || !trailing_space)
							put_char(h2t_pkg::CH_SPACE);
					end else begin
						put_char(c);
					end
				end
			endcase
			if (fin) begin
				add_result(16'h0000, 1'b0, 1'b1);
				clear_state();
			end
			if (step_q.size() > 0)
				step_q[step_q.size() - 1].last = 1'b1;
			foreach (step_q[k])
				plain_q.push_back(step_q[k]);
		endfunction

		function void compare_output(logic [15:0] data, logic [1:0] user, logic last);
			plain_result_t e;
			if (plain_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: data %h user %b last %b", data, user, last);
				return;
			end
			e = plain_q.pop_front();
			if (data !== e.unit || user[0] !== e.valid || user[1] !== e.text_end ||
			    last !== e.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: expected data %h valid %b end %b last %b",
					         e.unit, e.valid, e.text_end, e.last);
					$display("          got data %h valid %b end %b last %b",
					         data, user[0], user[1], last);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'h0000;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	plain_text_scoreboard sb;
	html_unit_t           stim_q[$];
	bit                   calm = 1'b0;
	bit                   hold_req = 1'b0;
	int                   quiet_cycles = 0;

	string       tag_names[$] = '{"br", "p", "/p", "br class=x", "p id=a", "div", "b", "brr",
	                              "/br", "BR", "pp", "br/", " br", "span style"};
	string       entity_names[$] = '{"amp", "lt", "gt", "quot", "apos", "nbsp", "am", "ampx",
	                                 "quots", "", "a p", "LT", "#38", "gtgtgt"};
	logic [15:0] blank_units[$] = '{16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h0020,
	                                16'h0085, 16'h00A0, 16'h1680, 16'h2000, 16'h2005, 16'h200A,
	                                16'h2028, 16'h2029, 16'h202F, 16'h205F, 16'h3000, 16'h200B,
	                                16'h0008, 16'h000E};
	logic [15:0] stray_units[$] = '{h2t_pkg::CH_LT, h2t_pkg::CH_AMP, h2t_pkg::CH_GT,
	                                h2t_pkg::CH_SEMI, h2t_pkg::CH_SPACE, h2t_pkg::CH_SLASH};

	html_to_plain_text_stream_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always #1 clk = ~clk;

	task automatic queue_unit(input logic [15:0] c, input logic fin);
		html_unit_t u;
		u.code = c;
		u.fin = fin;
		stim_q.push_back(u);
	endtask

	task automatic queue_word(input string s);
		for (int k = 0; k < s.len(); k++)
			queue_unit({8'h00, s[k]}, 1'b0);
	endtask

	task automatic mark_final();
		stim_q[stim_q.size() - 1].fin = 1'b1;
	endtask

	task automatic build_directed();
		queue_unit(16'h0041, 1'b0);
		queue_unit(h2t_pkg::CH_NBSP, 1'b0);
		queue_unit(16'h0009, 1'b0);
		queue_word("<br>");
		queue_unit(h2t_pkg::CH_NEWLINE, 1'b0);
		queue_word("&lt;");
		queue_word("<p>");
		queue_unit(16'hFFFF, 1'b0);
		queue_word("&x;");
		queue_unit(16'h0000, 1'b1);
		queue_word("<p");
		mark_final();
		queue_word("<br>");
		mark_final();
	endtask

	task automatic build_random(input int count);
		int target;
		int tokens;
		int kind;
		target = stim_q.size() + count;
		while (stim_q.size() < target) begin
			tokens = $urandom_range(1, 10);
			repeat (tokens) begin
				kind = $urandom_range(99);
				if (kind < 20)
					queue_unit(16'($urandom_range(25) + 97), 1'b0);
				else if (kind < 30)
					queue_unit(16'($urandom), 1'b0);
				else if (kind < 45)
					queue_unit(blank_units[$urandom_range(blank_units.size() - 1)], 1'b0);
				else if (kind < 68)
					queue_word({"<", tag_names[$urandom_range(tag_names.size() - 1)], ">"});
				else if (kind < 92)
					queue_word({"&", entity_names[$urandom_range(entity_names.size() - 1)], ";"});
				else
					queue_unit(stray_units[$urandom_range(stray_units.size() - 1)], 1'b0);
			end
			mark_final();
		end
	endtask

	task automatic send_unit(input logic [15:0] c, input logic fin);
		while (!calm && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.predict_unit(c, fin);
	endtask

	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= calm || ($urandom_range(99) >= 15);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.compare_output(m_tdata, m_tuser, m_tlast);
	end

	always @(posedge clk) begin
		if (arst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		int n_directed;
		sb = new();
		build_directed();
		n_directed = stim_q.size();
		build_random(RANDOM_UNITS);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < stim_q.size(); i++) begin
			calm = (i >= n_directed + 140 && i < n_directed + 200);
			if (i == n_directed + 60)
				hold_req = 1'b1;
			send_unit(stim_q[i].code, stim_q[i].fin);
		end
		s_tvalid <= 1'b0;
		calm = 1'b0;
		while (sb.plain_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.plain_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
